FILE: sv/olr_pkg.sv
`default_nettype none
package olr_pkg;

	// Result kinds carried in the low bits of each output word.
	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	// Characters with a meaning to the parser.
	localparam logic [7:0] CHAR_NEWLINE    = 8'd10;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CHAR_END_REC    = 8'h45;

	// Width of the packed output word, padded to whole bytes.
	localparam int RESULT_W = 58;
	localparam int OUT_DATA_W = 64;

	// One result word; the last member sits in the lowest bits.
	typedef struct packed {
		logic [23:0] prog_length;
		logic [7:0]  data_byte;
		logic [23:0] address;
		logic [1:0]  kind;
	} result_t;

	// Hex digit value of an ASCII character; anything else decodes as zero.
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: sv/olr_parser.sv
`default_nettype none
module olr_parser #(
	parameter int ADDR_DIGITS = 6
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire logic [7:0]      char_in,
	output logic                 res_valid,
	output olr_pkg::result_t     res
);

	localparam int CNT_W = $clog2(ADDR_DIGITS);
	localparam logic [CNT_W-1:0] ADDR_LAST = CNT_W'(ADDR_DIGITS - 1);
	localparam logic [CNT_W-1:0] LEN_LAST = CNT_W'(1);

	// Parser phases.
	localparam logic [3:0] PH_H_FIRST = 4'd0;
	localparam logic [3:0] PH_H_NAME  = 4'd1;
	localparam logic [3:0] PH_H_START = 4'd2;
	localparam logic [3:0] PH_H_LEN   = 4'd3;
	localparam logic [3:0] PH_H_SKIP  = 4'd4;
	localparam logic [3:0] PH_R_TYPE  = 4'd5;
	localparam logic [3:0] PH_E_ADDR  = 4'd6;
	localparam logic [3:0] PH_E_SKIP  = 4'd7;
	localparam logic [3:0] PH_T_ADDR  = 4'd8;
	localparam logic [3:0] PH_T_LEN   = 4'd9;
	localparam logic [3:0] PH_T_DATA  = 4'd10;

	logic [3:0]       phase_q, phase_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [23:0]      acc_q, acc_d;
	logic [23:0]      start_q, start_d;
	logic [23:0]      waddr_q, waddr_d;
	logic [3:0]       hnib_q, hnib_d;
	logic             pend_q, pend_d;

	logic             nl;
	logic [3:0]       hv;
	logic [23:0]      acc_sh;
	logic [CNT_W-1:0] count_inc;

	assign nl = (char_in == olr_pkg::CHAR_NEWLINE);
	assign hv = olr_pkg::hex_value(char_in);
	assign acc_sh = {acc_q[19:0], hv};
	assign count_inc = count_q + 1'b1;

	// Next-state and result logic for one character.
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		acc_d = acc_q;
		start_d = start_q;
		waddr_d = waddr_q;
		hnib_d = hnib_q;
		pend_d = pend_q;
		res_valid = 1'b0;
		res = '0;
		case (phase_q)
			PH_H_FIRST: begin
				if (!nl) phase_d = PH_H_NAME;
			end
			PH_H_NAME: begin
				if (nl) begin
					phase_d = PH_H_FIRST;
				end else if (char_in == olr_pkg::CHAR_UNDERSCORE) begin
					phase_d = PH_H_START;
					count_d = '0;
					acc_d = '0;
				end
			end
			PH_H_START: begin
				if (nl) begin
					phase_d = PH_H_FIRST;
					count_d = '0;
					acc_d = '0;
				end else if (count_q == ADDR_LAST) begin
					start_d = acc_sh;
					phase_d = PH_H_LEN;
					count_d = '0;
					acc_d = '0;
				end else begin
					acc_d = acc_sh;
					count_d = count_inc;
				end
			end
			PH_H_LEN: begin
				if (nl) begin
					phase_d = PH_H_FIRST;
					count_d = '0;
					acc_d = '0;
				end else if (count_q == ADDR_LAST) begin
					acc_d = acc_sh;
					count_d = '0;
					phase_d = PH_H_SKIP;
					res_valid = 1'b1;
					res.kind = olr_pkg::KIND_HEADER;
					res.address = start_q;
					res.prog_length = acc_sh;
				end else begin
					acc_d = acc_sh;
					count_d = count_inc;
				end
			end
			PH_H_SKIP: begin
				if (nl) phase_d = PH_R_TYPE;
			end
			PH_R_TYPE: begin
				if (!nl) begin
					phase_d = (char_in == olr_pkg::CHAR_END_REC) ? PH_E_ADDR : PH_T_ADDR;
					count_d = '0;
					acc_d = '0;
				end
			end
			PH_E_ADDR: begin
				if (nl) begin
					phase_d = PH_R_TYPE;
					count_d = '0;
					acc_d = '0;
				end else if (count_q == ADDR_LAST) begin
					acc_d = acc_sh;
					count_d = '0;
					phase_d = PH_E_SKIP;
					res_valid = 1'b1;
					res.kind = olr_pkg::KIND_END;
					res.address = acc_sh;
				end else begin
					acc_d = acc_sh;
					count_d = count_inc;
				end
			end
			PH_E_SKIP: begin
				if (nl) phase_d = PH_H_FIRST;
			end
			PH_T_ADDR: begin
				if (nl) begin
					phase_d = PH_R_TYPE;
					count_d = '0;
					acc_d = '0;
				end else if (count_q == ADDR_LAST) begin
					waddr_d = acc_sh;
					phase_d = PH_T_LEN;
					count_d = '0;
					acc_d = '0;
				end else begin
					acc_d = acc_sh;
					count_d = count_inc;
				end
			end
			PH_T_LEN: begin
				if (nl) begin
					phase_d = PH_R_TYPE;
					count_d = '0;
					acc_d = '0;
				end else if (count_q == LEN_LAST) begin
					acc_d = acc_sh;
					count_d = '0;
					phase_d = PH_T_DATA;
					pend_d = 1'b0;
				end else begin
					acc_d = acc_sh;
					count_d = count_inc;
				end
			end
			PH_T_DATA: begin
				if (nl) begin
					pend_d = 1'b0;
					phase_d = PH_R_TYPE;
				end else if (!pend_q) begin
					hnib_d = hv;
					pend_d = 1'b1;
				end else begin
					waddr_d = waddr_q + 24'd1;
					pend_d = 1'b0;
					res_valid = 1'b1;
					res.kind = olr_pkg::KIND_WRITE;
					res.address = waddr_q;
					res.data_byte = {hnib_q, hv};
				end
			end
			default: begin
				// Unused phase codes return the parser to its reset state.
				phase_d = PH_H_FIRST;
				count_d = '0;
				acc_d = '0;
				start_d = '0;
				waddr_d = '0;
				hnib_d = '0;
				pend_d = 1'b0;
			end
		endcase
	end

	// Parser state advances on each accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_H_FIRST;
			count_q <= '0;
			acc_q <= '0;
			start_q <= '0;
			waddr_q <= '0;
			hnib_q <= '0;
			pend_q <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			count_q <= count_d;
			acc_q <= acc_d;
			start_q <= start_d;
			waddr_q <= waddr_d;
			hnib_q <= hnib_d;
			pend_q <= pend_d;
		end
	end

endmodule
`default_nettype wire

FILE: sv/olr_skid.sv
`default_nettype none
module olr_skid (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire olr_pkg::result_t     push_data,
	output logic                      can_push,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output olr_pkg::result_t          out_data
);

	logic             out_valid_q;
	olr_pkg::result_t out_q;
	logic             skid_valid_q;
	olr_pkg::result_t skid_q;
	logic             pop;

	assign can_push = !skid_valid_q;
	assign pop = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// Valid flags of the output register and the skid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves; the skid holds a word while the output is stalled.
	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule
`default_nettype wire

FILE: sv/object_record_loader_top.sv
// Object record loader: parses an absolute object program, one character per word.
// A completed result word is registered in the output register or the skid.
// Throughput: one character per cycle; the two-entry output skid keeps s_axis_tready
// registered, so input flow stops only after two results wait unread.
// Reset: arst_n clears the parser to wait for a header line and empties the output.
`default_nettype none
module object_record_loader_top #(
	parameter int ADDR_DIGITS = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata    // [1:0] kind, [25:2] address,
	                                         // [33:26] data_byte, [57:34] prog_length
);

	logic             take;
	logic             res_valid;
	olr_pkg::result_t res;
	olr_pkg::result_t out_res;

	assign take = s_axis_tvalid && s_axis_tready;

	// Character parser with its record state.
	olr_parser #(
		.ADDR_DIGITS(ADDR_DIGITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.char_in   (s_axis_tdata),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register with skid stage.
	olr_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && res_valid),
		.push_data (res),
		.can_push  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tdata = {(olr_pkg::OUT_DATA_W - olr_pkg::RESULT_W)'(0), out_res};

endmodule
`default_nettype wire

FILE: bench/object_record_loader_top_test.sv
`default_nettype none
module object_record_loader_top_test;

	localparam int ADDR_DIGITS = 6;
	localparam int STALL_MAX = 13;
	localparam int RESET_CYCLES = 10;
	localparam int TAIL_CYCLES = 8;
	localparam int QUIET_LIMIT = 300;
	localparam int RANDOM_CHARS = 400;
	localparam int REPORT_MAX = 10;

	// Parser phases, walked in the same order as the object file is read.
	typedef enum logic [3:0] {
		HDR_FIRST,
		HDR_NAME,
		HDR_START,
		HDR_LEN,
		HDR_TAIL,
		REC_TYPE,
		END_ADDR,
		END_TAIL,
		TXT_ADDR,
		TXT_LEN,
		TXT_DATA
	} parse_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;

	// Expected load actions, oldest first.
	olr_pkg::result_t pending_loads[$];

	// Predicted parser state.
	parse_phase_t phase;
	int           digits_seen;
	logic [23:0]  field_acc;
	logic [23:0]  start_hold;
	logic [23:0]  load_addr;
	logic [3:0]   upper_nibble;
	logic         nibble_held;

	// Run bookkeeping.
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int chars_sent = 0;
	int failures = 0;
	int quiet_cycles = 0;
	int headers_seen = 0;
	int writes_seen = 0;
	int entries_seen = 0;

	object_record_loader_top #(
		.ADDR_DIGITS(ADDR_DIGITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hex digit value of a character; anything that is not a hex digit counts as zero.
	function automatic logic [3:0] digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 4'(c - "0");
		if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
		if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
		return 4'd0;
	endfunction

	function automatic void reset_parser();
		phase = HDR_FIRST;
		digits_seen = 0;
		field_acc = '0;
		start_hold = '0;
		load_addr = '0;
		upper_nibble = '0;
		nibble_held = 1'b0;
	endfunction

	function automatic void open_field(input parse_phase_t next);
		phase = next;
		digits_seen = 0;
		field_acc = '0;
	endfunction

	// Shifts one digit into the field; true once the field has n digits.
	function automatic bit shift_digit(input logic [7:0] c, input int n);
		field_acc = {field_acc[19:0], digit_value(c)};
		digits_seen++;
		if (digits_seen >= n) begin
			digits_seen = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void queue_load(input logic [1:0] kind, input logic [23:0] address,
			input logic [7:0] data_byte, input logic [23:0] prog_length);
		olr_pkg::result_t r;
		r.kind = kind;
		r.address = address;
		r.data_byte = data_byte;
		r.prog_length = prog_length;
		pending_loads.push_back(r);
		case (kind)
			olr_pkg::KIND_HEADER: headers_seen++;
			olr_pkg::KIND_END: entries_seen++;
			default: writes_seen++;
		endcase
	endfunction

	// Advances the predicted parser by one accepted character.
	function automatic void parse_char(input logic [7:0] c);
		bit nl;
		nl = (c == olr_pkg::CHAR_NEWLINE);
		case (phase)
			HDR_FIRST: if (!nl) phase = HDR_NAME;
			HDR_NAME: begin
				if (nl) phase = HDR_FIRST;
				else if (c == olr_pkg::CHAR_UNDERSCORE) open_field(HDR_START);
			end
			HDR_START: begin
				if (nl) begin
					open_field(HDR_FIRST);
				end else if (shift_digit(c, ADDR_DIGITS)) begin
					start_hold = field_acc;
					open_field(HDR_LEN);
				end
			end
			HDR_LEN: begin
				if (nl) begin
					open_field(HDR_FIRST);
				end else if (shift_digit(c, ADDR_DIGITS)) begin
					phase = HDR_TAIL;
					queue_load(olr_pkg::KIND_HEADER, start_hold, 8'd0, field_acc);
				end
			end
			HDR_TAIL: if (nl) phase = REC_TYPE;
			REC_TYPE: begin
				if (!nl) begin
					if (c == olr_pkg::CHAR_END_REC) open_field(END_ADDR);
					else open_field(TXT_ADDR);
				end
			end
			END_ADDR: begin
				if (nl) begin
					open_field(REC_TYPE);
				end else if (shift_digit(c, ADDR_DIGITS)) begin
					phase = END_TAIL;
					queue_load(olr_pkg::KIND_END, field_acc, 8'd0, 24'd0);
				end
			end
			END_TAIL: if (nl) phase = HDR_FIRST;
			TXT_ADDR: begin
				if (nl) begin
					open_field(REC_TYPE);
				end else if (shift_digit(c, ADDR_DIGITS)) begin
					load_addr = field_acc;
					open_field(TXT_LEN);
				end
			end
			TXT_LEN: begin
				if (nl) begin
					open_field(REC_TYPE);
				end else if (shift_digit(c, 2)) begin
					phase = TXT_DATA;
					nibble_held = 1'b0;
				end
			end
			TXT_DATA: begin
				if (nl) begin
					nibble_held = 1'b0;
					phase = REC_TYPE;
				end else if (!nibble_held) begin
					upper_nibble = digit_value(c);
					nibble_held = 1'b1;
				end else begin
					queue_load(olr_pkg::KIND_WRITE, load_addr,
						{upper_nibble, digit_value(c)}, 24'd0);
					load_addr = load_addr + 24'd1;
					nibble_held = 1'b0;
				end
			end
			default: reset_parser();
		endcase
	endfunction

	function automatic void note_failure(input string msg);
		failures++;
		if (failures <= REPORT_MAX) $display("%s", msg);
	endfunction

	// Compares each output word with the oldest expected load action.
	always @(posedge clk) begin
		olr_pkg::result_t got;
		olr_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = olr_pkg::result_t'(m_axis_tdata[olr_pkg::RESULT_W-1:0]);
			if (pending_loads.size() == 0) begin
				note_failure($sformatf("unexpected word %h", m_axis_tdata));
			end else begin
				want = pending_loads.pop_front();
				if (got.kind !== want.kind || got.address !== want.address
						|| got.data_byte !== want.data_byte
						|| got.prog_length !== want.prog_length
						|| m_axis_tdata[63:olr_pkg::RESULT_W] !== '0) begin
					note_failure($sformatf({"mismatch: expected kind %0d addr %h data %h ",
						"len %h, got kind %0d addr %h data %h len %h pad %h"},
						want.kind, want.address, want.data_byte, want.prog_length,
						got.kind, got.address, got.data_byte, got.prog_length,
						m_axis_tdata[63:olr_pkg::RESULT_W]));
				end
			end
		end
	end

	// Ends the run when no word moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Output side: while rx_idle is set, holds off for a random stall before taking each word.
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = rx_idle ? $urandom_range(0, STALL_MAX) : 0;
			repeat (stall) begin
				@(negedge clk);
				m_axis_tready = 1'b0;
			end
			@(negedge clk);
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Sends one character, after a random gap while tx_idle is set, and predicts its effect once taken.
	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = tx_idle ? $urandom_range(0, STALL_MAX) : 0;
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = c;
		do @(posedge clk); while (!s_axis_tready);
		parse_char(c);
		chars_sent++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
	endtask

	task automatic wait_for_results();
		stop_sending();
		while (pending_loads.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == olr_pkg::CHAR_NEWLINE);
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		if (d < 4'd10) return 8'("0" + d);
		return 8'(($urandom_range(0, 1) ? "a" : "A") + d - 4'd10);
	endfunction

	// Sends n digits of v (digit i from v[(i % 8)*4 +: 4]), most significant first, a rare one a stray character.
	task automatic send_hex(input logic [31:0] v, input int n);
		for (int i = n - 1; i >= 0; i--) begin
			if ($urandom_range(0, 19) == 0) send_char(junk_char());
			else send_char(hex_char(v[(i % 8) * 4 +: 4]));
		end
	endtask

	// Mostly random addresses, sometimes right below the wrap point.
	function automatic logic [23:0] pick_address();
		if ($urandom_range(0, 7) == 0) return 24'hFFFFFF - 24'($urandom_range(0, 3));
		return 24'($urandom);
	endfunction

	task automatic test_header_parsing();
		// Blank line, a newline inside the name, a newline inside the start digits,
		// then a header with extreme values in mixed case and a trailing remark.
		send_text("\nH\nH_12\n");
		send_text("HPROG_FFFFFFffffff!\n");
		send_text("X_000000000000\n");
	endtask

	task automatic test_text_records();
		logic [7:0] tail;
		// Empty line, then records abandoned in the address and in the length.
		send_text("\nT12\nT0000001\n");
		// Writes that wrap the address, a non-hex digit, and an unpaired last digit.
		send_text("TFFFFFE00fFz9001\n");
		tail = 8'hFF;
		send_char(tail);
		send_text("0000003080\n");
	endtask

	task automatic test_end_record();
		// Abandoned end record, then one with a non-hex digit and ignored text after it.
		send_text("E12\nEg0000A tail\n");
		// Characters after the end line belong to a new header.
		send_text("H_00007F000010\nE00007F\n");
	endtask

	task automatic send_random_program();
		int n_rec;
		int n_pairs;
		logic [7:0] c;
		if ($urandom_range(0, 3) == 0) send_char(olr_pkg::CHAR_NEWLINE);
		// Occasionally a header cut short by a newline.
		if ($urandom_range(0, 7) == 0) begin
			send_char(junk_char());
			send_char(olr_pkg::CHAR_UNDERSCORE);
			send_hex($urandom, $urandom_range(0, 11));
			send_char(olr_pkg::CHAR_NEWLINE);
		end
		send_char(junk_char());
		repeat ($urandom_range(0, 5)) begin
			do c = junk_char(); while (c == olr_pkg::CHAR_UNDERSCORE);
			send_char(c);
		end
		send_char(olr_pkg::CHAR_UNDERSCORE);
		send_hex(pick_address(), ADDR_DIGITS);
		send_hex($urandom, ADDR_DIGITS);
		repeat ($urandom_range(0, 3)) send_char(junk_char());
		send_char(olr_pkg::CHAR_NEWLINE);
		n_rec = $urandom_range(1, 5);
		repeat (n_rec) begin
			case ($urandom_range(0, 9))
				0: send_char(olr_pkg::CHAR_NEWLINE);
				1: begin
					send_char("T");
					send_hex($urandom, $urandom_range(0, ADDR_DIGITS + 1));
					send_char(olr_pkg::CHAR_NEWLINE);
				end
				2: begin
					send_char(olr_pkg::CHAR_END_REC);
					send_hex($urandom, $urandom_range(0, ADDR_DIGITS - 1));
					send_char(olr_pkg::CHAR_NEWLINE);
				end
				default: begin
					do c = junk_char(); while (c == olr_pkg::CHAR_END_REC);
					send_char(c);
					send_hex(pick_address(), ADDR_DIGITS);
					send_hex($urandom, 2);
					n_pairs = $urandom_range(0, 8);
					repeat (n_pairs) send_hex($urandom, 2);
					if ($urandom_range(0, 3) == 0) send_hex($urandom, 1);
					send_char(olr_pkg::CHAR_NEWLINE);
				end
			endcase
		end
		send_char(olr_pkg::CHAR_END_REC);
		send_hex(pick_address(), ADDR_DIGITS);
		repeat ($urandom_range(0, 3)) send_char(junk_char());
		send_char(olr_pkg::CHAR_NEWLINE);
	endtask

	task automatic test_random_programs();
		int goal;
		goal = chars_sent + RANDOM_CHARS;
		while (chars_sent < goal) begin
			// Each program runs with its own mix of idle and busy sides.
			tx_idle = $urandom_range(0, 1);
			rx_idle = $urandom_range(0, 1);
			send_random_program();
			if ($urandom_range(0, 5) == 0) wait_for_results();
		end
	endtask

	initial begin
		reset_parser();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_header_parsing();
		test_text_records();
		test_end_record();
		// Hold the input until every word so far has been read out.
		wait_for_results();
		test_random_programs();

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_loads.size() != 0) begin
			note_failure($sformatf("%0d words never arrived", pending_loads.size()));
		end
		$display("Sent %0d characters of object programs, clean and malformed.", chars_sent);
		$display("Checked %0d headers, %0d memory writes and %0d entry points; %0d failures.",
			headers_seen, writes_seen, entries_seen, failures);
		if (failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: object_record_loader_top.f
sv/olr_pkg.sv
sv/olr_parser.sv
sv/olr_skid.sv
sv/object_record_loader_top.sv
bench/object_record_loader_top_test.sv
